// ===== hdl/wtou_pkg.sv =====
// Shared constants and types for the window-to-object unprojection block.
// No dependencies; imported by the top level only.
package wtou_pkg;

  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int VP_W        = 13;
  localparam int COEF_W      = 16;
  localparam int DEPTH_W     = 16;
  localparam int OUT_W       = 32;
  localparam int FRAC_W      = 16;

  localparam int COORD_WIDTH_DEF    = 12;
  localparam int COEF_FRAC_BITS_DEF = 12;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd5;

  localparam logic [OUT_W-1:0] SAT_POS_VAL = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] SAT_NEG_VAL = 32'h8000_0000;

  // How a result lane is finished after the final division.
  typedef enum logic [1:0] {
    LANE_NORMAL,
    LANE_SAT_POS,
    LANE_SAT_NEG,
    LANE_ZERO
  } lane_code_t;

  // Per-item side information carried alongside the final division.
  typedef struct packed {
    logic             wzero;
    logic [2:0]       neg;
    lane_code_t [2:0] code;
  } quo_side_t;

endpackage

// ===== hdl/wtou_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage, several lanes.
// Depends on nothing; used by window_to_object_unproject.
module wtou_div_pipe #(
  parameter int LANES = 2,
  parameter int QW    = 29,
  parameter int RW    = 13,
  parameter int PW    = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][RW-1:0]   r0,
  input  logic [LANES-1:0][QW-1:0]   bits,
  input  logic [LANES-1:0][RW-1:0]   den,
  input  logic [PW-1:0]              side,
  output logic                       out_valid,
  output logic [LANES-1:0][QW-1:0]   quo,
  output logic [PW-1:0]              out_side
);

  // Partial remainder, divisor and remaining dividend bits exist only up to
  // the stage before the last; the last stage keeps just the quotient, side data and valid.
  logic [LANES-1:0][RW-1:0] sr [QW-1];
  logic [LANES-1:0][RW-1:0] sd [QW-1];
  logic [LANES-1:0][QW-1:0] sb [QW-1];
  logic [LANES-1:0][QW-1:0] sq [QW];
  logic [PW-1:0]            sp [QW];
  logic                     sv [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [LANES-1:0][RW-1:0] r_in, d_in, r_nx;
    logic [LANES-1:0][QW-1:0] b_in, q_in, q_nx;
    logic [PW-1:0]            p_in;
    logic                     v_in;

    if (s == 0) begin : g_first
      assign r_in = r0;
      assign d_in = den;
      assign b_in = bits;
      assign q_in = '0;
      assign p_in = side;
      assign v_in = in_valid;
    end else begin : g_next
      assign r_in = sr[s-1];
      assign d_in = sd[s-1];
      assign b_in = sb[s-1];
      assign q_in = sq[s-1];
      assign p_in = sp[s-1];
      assign v_in = sv[s-1];
    end

    always_comb begin
      logic [RW:0] t;
      for (int l = 0; l < LANES; l++) begin
        t = {r_in[l], b_in[l][QW-1]};
        if (t >= {1'b0, d_in[l]}) begin
          r_nx[l] = RW'(t - {1'b0, d_in[l]});
          q_nx[l] = {q_in[l][QW-2:0], 1'b1};
        end else begin
          r_nx[l] = t[RW-1:0];
          q_nx[l] = {q_in[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[s] <= 1'b0;
      end else if (en) begin
        sv[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq[s] <= q_nx;
        sp[s] <= p_in;
      end
    end

    if (s < QW - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          sr[s] <= r_nx;
          sd[s] <= d_in;
          sb[s] <= b_in << 1;
        end
      end
    end
  end

  assign out_valid = sv[QW-1];
  assign quo       = sq[QW-1];
  assign out_side  = sp[QW-1];

endmodule

// ===== hdl/window_to_object_unproject.sv =====
// Top level of the window-to-object unprojection pipeline.
// Depends on wtou_pkg and wtou_div_pipe.
//
// Takes one pixel (win_x, win_y, depth_value) per cycle while in_stall is low and returns
// one object-space point in signed Q16.16 per item, in order. The pipeline holds
// COORD_WIDTH + 17 stages of the viewport divider, one stage each for the NDC offsets,
// the twelve coefficient products, the row sums and the sign/overflow preparation,
// 32 stages of the perspective divider and the output register. The whole pipeline
// advances together; while a finished item waits at the output under stall,
// in_stall is raised and nothing moves. Configuration must be written through
// cfg_we/cfg_index/cfg_data only while no item is in flight; the block itself does
// not enforce this. Writes to unknown indexes are ignored.
module window_to_object_unproject #(
  parameter int COORD_WIDTH    = wtou_pkg::COORD_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = wtou_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [wtou_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wtou_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [COORD_WIDTH-1:0]          win_x,
  input  logic [COORD_WIDTH-1:0]          win_y,
  input  logic [wtou_pkg::DEPTH_W-1:0]    depth_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [wtou_pkg::OUT_W-1:0] obj_x,
  output logic signed [wtou_pkg::OUT_W-1:0] obj_y,
  output logic signed [wtou_pkg::OUT_W-1:0] obj_z,
  output logic                            range_error
);
  import wtou_pkg::*;

  localparam int QW1 = COORD_WIDTH + 17;   // width of (2*coord) << 16
  localparam int NW  = COORD_WIDTH + 18;   // signed NDC value
  localparam int PRW = NW + COEF_W;        // one coefficient product
  localparam int UW  = PRW + 2;            // sum of four products
  localparam int PW2 = $bits(quo_side_t);

  // Configuration registers.
  logic [CFG_W-1:0] matrix_row [4];
  logic [VP_W-1:0]  vp_width, vp_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 4; r++) begin
        matrix_row[r] <= CFG_W'(65'd1 << (COEF_FRAC_BITS + 16 * r));
      end
      vp_width  <= VP_W'(1);
      vp_height <= VP_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW0:   matrix_row[0] <= cfg_data;
        REG_ROW1:   matrix_row[1] <= cfg_data;
        REG_ROW2:   matrix_row[2] <= cfg_data;
        REG_ROW3:   matrix_row[3] <= cfg_data;
        REG_WIDTH:  vp_width      <= cfg_data[VP_W-1:0];
        REG_HEIGHT: vp_height     <= cfg_data[VP_W-1:0];
        default: ;
      endcase
    end
  end

  logic [VP_W-1:0] wd_eff, ht_eff;
  assign wd_eff = (vp_width  == '0) ? VP_W'(1) : vp_width;
  assign ht_eff = (vp_height == '0) ? VP_W'(1) : vp_height;

  // Every stage moves together unless the output holds a waiting item.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Viewport division: floor((coord << 17) / size) for x and y.
  logic                           d1_v;
  logic [1:0][QW1-1:0]            d1_q;
  logic [DEPTH_W-1:0]             d1_depth;

  wtou_div_pipe #(
    .LANES(2), .QW(QW1), .RW(VP_W), .PW(DEPTH_W)
  ) u_vp_div (
    .clk, .rst, .en,
    .in_valid (in_valid),
    .r0       ('0),
    .bits     ({{win_y, 17'b0}, {win_x, 17'b0}}),
    .den      ({ht_eff, wd_eff}),
    .side     (depth_value),
    .out_valid(d1_v),
    .quo      (d1_q),
    .out_side (d1_depth)
  );

  // NDC stage.
  logic                  n_v;
  logic signed [NW-1:0]  n_x, n_y, n_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_v <= 1'b0;
    end else if (en) begin
      n_v <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_x <= $signed({1'b0, d1_q[0]}) - NW'(65536);
      n_y <= NW'(65536) - $signed({1'b0, d1_q[1]});
      n_z <= $signed(NW'({d1_depth, 1'b0})) - NW'(65536);
    end
  end

  // Product stage; the w column multiplies by one, a plain shift.
  logic                   m_v;
  logic signed [PRW-1:0]  prod [4][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (en) begin
      m_v <= n_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        prod[r][0] <= $signed(matrix_row[r][15:0])  * n_x;
        prod[r][1] <= $signed(matrix_row[r][31:16]) * n_y;
        prod[r][2] <= $signed(matrix_row[r][47:32]) * n_z;
        prod[r][3] <= PRW'($signed(matrix_row[r][63:48])) <<< FRAC_W;
      end
    end
  end

  // Row sums.
  logic                  a_v;
  logic signed [UW-1:0]  u [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        u[r] <= (UW'(prod[r][0]) + UW'(prod[r][1])) + (UW'(prod[r][2]) + UW'(prod[r][3]));
      end
    end
  end

  // Preparation: magnitudes, signs and the cases that skip the division.
  logic [UW-1:0] ud_c;
  logic          wz_c;
  logic [2:0][UW-1:0] un_c;
  quo_side_t     side_c;

  always_comb begin
    ud_c = u[3][UW-1] ? UW'(-u[3]) : UW'(u[3]);
    wz_c = (u[3] == '0);
    side_c.wzero = wz_c;
    for (int l = 0; l < 3; l++) begin
      un_c[l] = u[l][UW-1] ? UW'(-u[l]) : UW'(u[l]);
      side_c.neg[l] = u[l][UW-1] ^ u[3][UW-1];
      if (wz_c) begin
        if (u[l] == '0) begin
          side_c.code[l] = LANE_ZERO;
        end else if (u[l][UW-1]) begin
          side_c.code[l] = LANE_SAT_NEG;
        end else begin
          side_c.code[l] = LANE_SAT_POS;
        end
      end else if ({16'b0, un_c[l]} >= {ud_c, 16'b0}) begin
        // Integer part would not fit in sixteen bits.
        side_c.code[l] = side_c.neg[l] ? LANE_SAT_NEG : LANE_SAT_POS;
      end else begin
        side_c.code[l] = LANE_NORMAL;
      end
    end
  end

  logic               p_v;
  logic [2:0][UW-1:0] p_un;
  logic [UW-1:0]      p_ud;
  quo_side_t          p_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (en) begin
      p_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_un   <= un_c;
      p_ud   <= ud_c;
      p_side <= side_c;
    end
  end

  // Perspective division: 32 quotient bits of (un << 16) / ud.
  logic [2:0][UW-1:0] r0_2, den_2;
  logic [2:0][31:0]   bits_2;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      r0_2[l]   = p_un[l] >> FRAC_W;
      bits_2[l] = {p_un[l][FRAC_W-1:0], 16'b0};
      den_2[l]  = p_ud;
    end
  end

  logic             d2_v;
  logic [2:0][31:0] d2_q;
  logic [PW2-1:0]   d2_side_raw;
  quo_side_t        d2_side;

  wtou_div_pipe #(
    .LANES(3), .QW(OUT_W), .RW(UW), .PW(PW2)
  ) u_persp_div (
    .clk, .rst, .en,
    .in_valid (p_v),
    .r0       (r0_2),
    .bits     (bits_2),
    .den      (den_2),
    .side     (p_side),
    .out_valid(d2_v),
    .quo      (d2_q),
    .out_side (d2_side_raw)
  );

  assign d2_side = quo_side_t'(d2_side_raw);

  // Final signs and saturation.
  logic [2:0][OUT_W-1:0] res_c;
  logic                  err_c;

  always_comb begin
    logic [OUT_W-1:0] lim;
    err_c = d2_side.wzero;
    for (int l = 0; l < 3; l++) begin
      lim = d2_side.neg[l] ? SAT_NEG_VAL : SAT_POS_VAL;
      unique case (d2_side.code[l])
        LANE_NORMAL: begin
          if (d2_q[l] > lim) begin
            res_c[l] = lim;
            err_c    = 1'b1;
          end else begin
            res_c[l] = d2_side.neg[l] ? OUT_W'(-d2_q[l]) : d2_q[l];
          end
        end
        LANE_SAT_POS: begin
          res_c[l] = SAT_POS_VAL;
          err_c    = 1'b1;
        end
        LANE_SAT_NEG: begin
          res_c[l] = SAT_NEG_VAL;
          err_c    = 1'b1;
        end
        LANE_ZERO: res_c[l] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      obj_x       <= $signed(res_c[0]);
      obj_y       <= $signed(res_c[1]);
      obj_z       <= $signed(res_c[2]);
      range_error <= err_c;
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold_output: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(obj_x) && $stable(range_error))
    else $error("stalled output item changed");

  a_zero_w_flags: assert property (@(posedge clk) disable iff (rst)
    d2_v && en && d2_side.wzero |=> range_error)
    else $error("zero w did not raise range_error");

endmodule
